[rtl/qhpn_pkg.sv]
// ----------------------------------------------------------------------------
// QUIC header protection package
// Shared types and constants for the header unprotect and packet number
// decode pipeline.
// ----------------------------------------------------------------------------
package qhpn_pkg;

   localparam int PN_W       = 62;
   localparam int EXP_W      = 63;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 112;

   localparam logic [EXP_W-1:0] PN_BOUND = 63'h4000_0000_0000_0000;
   localparam logic [PN_W-1:0]  PN_MAX62 = {PN_W{1'b1}};

   localparam logic [7:0] BITS_SHORT    = 8'h1F;
   localparam logic [7:0] BITS_LONG     = 8'h0F;
   localparam int         PHASE_BIT_POS = 2;

   localparam logic OP_REMOVE = 1'b0;
   localparam logic OP_APPLY  = 1'b1;

   localparam logic [1:0] KEY_CURRENT  = 2'd0;
   localparam logic [1:0] KEY_PREVIOUS = 2'd1;
   localparam logic [1:0] KEY_NEXT     = 2'd2;

   localparam logic CSR_KEY_PHASE  = 1'b0;
   localparam logic CSR_LOWEST_PN  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic        short_header;
      logic [7:0]  first_byte_out;
      logic [31:0] pn_field_out;
      logic [2:0]  pn_len;
   } hdr_type;

   typedef struct packed {
      hdr_type          hdr;
      logic [1:0]       dec_len;
      logic [31:0]      trunc;
      logic [EXP_W-1:0] expected;
   } unmask_type;

   typedef struct packed {
      hdr_type          hdr;
      logic [EXP_W-1:0] expected;
      logic [32:0]      win;
      logic [EXP_W-1:0] cand;
      logic [EXP_W:0]   cand_hi;
      logic [EXP_W:0]   exp_hi;
      logic [EXP_W-1:0] lim;
      logic [EXP_W-1:0] cand_up;
      logic [EXP_W-1:0] cand_dn;
   } window_type;

   typedef struct packed {
      hdr_type          hdr;
      logic [EXP_W-1:0] res;
   } select_type;

   typedef struct packed {
      logic [7:0]      first_byte_out;
      logic [31:0]     pn_field_out;
      logic [2:0]      pn_len;
      logic [PN_W-1:0] packet_number;
      logic [1:0]      key_set;
   } rsp_type;

endpackage

[rtl/qhpn_unmask.sv]
// ----------------------------------------------------------------------------
// Header unmask stage
// Masks byte 0 and the packet number bytes, finds the length and the
// truncated number, and forms the expected packet number.
// ----------------------------------------------------------------------------
module qhpn_unmask
   import qhpn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              operation,
   input  logic              short_header,
   input  logic [7:0]        first_byte,
   input  logic [31:0]       pn_field,
   input  logic [39:0]       mask,
   input  logic [2:0]        pn_len_in,
   input  logic [PN_W-1:0]   max_rx_pn,
   output logic              out_valid,
   input  logic              out_ready,
   output unmask_type        out_data
);

   logic       valid_ff;
   logic       valid_in;
   unmask_type data_ff;
   unmask_type data_in;
   logic [7:0]  fb_out;
   logic [2:0]  len;
   logic [31:0] field_out;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      fb_out = first_byte ^ (mask[39:32] & (short_header ? BITS_SHORT : BITS_LONG));
      if (operation == OP_APPLY) begin
         len = pn_len_in;
      end else begin
         len = {1'b0, fb_out[1:0]} + 3'd1;
      end
      field_out = pn_field;
      for (int i = 0; i < 4; i++) begin
         if (len > 3'(i)) begin
            field_out[31-8*i -: 8] = pn_field[31-8*i -: 8] ^ mask[31-8*i -: 8];
         end
      end
   end

   always_comb begin
      data_in.hdr.operation      = operation;
      data_in.hdr.short_header   = short_header;
      data_in.hdr.first_byte_out = fb_out;
      data_in.hdr.pn_field_out   = field_out;
      data_in.hdr.pn_len         = len;
      data_in.dec_len            = fb_out[1:0];
      data_in.expected           = {1'b0, max_rx_pn} + 63'd1;
      case (fb_out[1:0])
         2'd0: begin
            data_in.trunc = {24'd0, field_out[31:24]};
         end
         2'd1: begin
            data_in.trunc = {16'd0, field_out[31:16]};
         end
         2'd2: begin
            data_in.trunc = {8'd0, field_out[31:8]};
         end
         default: begin
            data_in.trunc = field_out;
         end
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/qhpn_window.sv]
// ----------------------------------------------------------------------------
// Packet number window stages
// Two register stages: the first forms the candidate and its window
// bounds, the second compares them and picks the decoded number.
// ----------------------------------------------------------------------------
module qhpn_window
   import qhpn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  unmask_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output select_type out_data
);

   logic       win_valid_ff;
   logic       win_valid_in;
   window_type win_ff;
   window_type win_in;
   logic       win_ready;
   logic       sel_valid_ff;
   logic       sel_valid_in;
   select_type sel_ff;
   select_type sel_in;
   logic [32:0]      win;
   logic [32:0]      hwin;
   logic [EXP_W-1:0] wmask;
   logic [EXP_W-1:0] cand;
   logic             go_up;
   logic             go_down;

   assign win_ready = !sel_valid_ff || out_ready;
   assign in_ready  = !win_valid_ff || win_ready;

   always_comb begin
      case (in_data.dec_len)
         2'd0: begin
            win = 33'h0_0000_0100;
         end
         2'd1: begin
            win = 33'h0_0001_0000;
         end
         2'd2: begin
            win = 33'h0_0100_0000;
         end
         default: begin
            win = 33'h1_0000_0000;
         end
      endcase
      hwin  = win >> 1;
      wmask = 63'(win) - 63'd1;
      cand  = (in_data.expected & ~wmask) | 63'(in_data.trunc);
      win_in.hdr      = in_data.hdr;
      win_in.expected = in_data.expected;
      win_in.win      = win;
      win_in.cand     = cand;
      win_in.cand_hi  = 64'(cand) + 64'(hwin);
      win_in.exp_hi   = 64'(in_data.expected) + 64'(hwin);
      win_in.lim      = PN_BOUND - 63'(win);
      win_in.cand_up  = cand + 63'(win);
      win_in.cand_dn  = cand - 63'(win);
      win_valid_in    = in_ready ? in_valid : win_valid_ff;
   end

   always_comb begin
      go_up   = (win_ff.cand_hi <= 64'(win_ff.expected)) && (win_ff.cand < win_ff.lim);
      go_down = (64'(win_ff.cand) > win_ff.exp_hi) && (win_ff.cand >= 63'(win_ff.win));
      sel_in.hdr = win_ff.hdr;
      if (go_up) begin
         sel_in.res = win_ff.cand_up;
      end else if (go_down) begin
         sel_in.res = win_ff.cand_dn;
      end else begin
         sel_in.res = win_ff.cand;
      end
      sel_valid_in = win_ready ? win_valid_ff : sel_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         sel_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
         sel_valid_ff <= sel_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         win_ff <= win_in;
      end
      if (win_ready && win_valid_ff) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = sel_valid_ff;
   assign out_data  = sel_ff;

endmodule

[rtl/qhpn_resolve.sv]
// ----------------------------------------------------------------------------
// Result stage
// Saturates the decoded number, picks the key set and holds the
// finished response in the output register.
// ----------------------------------------------------------------------------
module qhpn_resolve
   import qhpn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  select_type      in_data,
   input  logic            rx_phase,
   input  logic [PN_W-1:0] lowest_pn,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_type         out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;
   logic    removing;
   logic    phase_flip;
   logic    below_lowest;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      removing     = (in_data.hdr.operation == OP_REMOVE);
      phase_flip   = in_data.hdr.first_byte_out[PHASE_BIT_POS] ^ rx_phase;
      below_lowest = in_data.res < {1'b0, lowest_pn};
      data_in.first_byte_out = in_data.hdr.first_byte_out;
      data_in.pn_field_out   = in_data.hdr.pn_field_out;
      data_in.pn_len         = in_data.hdr.pn_len;
      if (!removing) begin
         data_in.packet_number = '0;
      end else if (in_data.res[EXP_W-1]) begin
         data_in.packet_number = PN_MAX62;
      end else begin
         data_in.packet_number = in_data.res[PN_W-1:0];
      end
      if (removing && in_data.hdr.short_header && phase_flip) begin
         data_in.key_set = below_lowest ? KEY_PREVIOUS : KEY_NEXT;
      end else begin
         data_in.key_set = KEY_CURRENT;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/quic_header_unprotect_pn_decode.sv]
// ----------------------------------------------------------------------------
// QUIC header unprotect and packet number decode
// A request passes the unmask, window, select and result registers in turn
// before rsp_tvalid rises for it. One request is taken per cycle while
// rsp_tready keeps up; each of the four register stages moves when its
// successor has room, so stalls lose and repeat nothing.
// Reset clears every stage valid bit and both configuration registers.
// ----------------------------------------------------------------------------
module quic_header_unprotect_pn_decode
   import qhpn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: first_byte, pn_field, mask, pn_len_in, largest_pn.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: operation, short_header.
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: first_byte_out, pn_field_out, pn_len, packet_number,
   // key_set.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [PN_W-1:0]       csr_wdata
);

   logic            rx_phase_ff;
   logic            rx_phase_in;
   logic [PN_W-1:0] lowest_pn_ff;
   logic [PN_W-1:0] lowest_pn_in;

   logic       s1_valid;
   logic       s1_ready;
   unmask_type s1_data;
   logic       s3_valid;
   logic       s3_ready;
   select_type s3_data;
   rsp_type    rsp;

   always_comb begin
      rx_phase_in  = rx_phase_ff;
      lowest_pn_in = lowest_pn_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_PHASE: begin
               rx_phase_in = csr_wdata[0];
            end
            CSR_LOWEST_PN: begin
               lowest_pn_in = csr_wdata;
            end
            default: begin
               rx_phase_in = rx_phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff  <= 1'b0;
         lowest_pn_ff <= '0;
      end else begin
         rx_phase_ff  <= rx_phase_in;
         lowest_pn_ff <= lowest_pn_in;
      end
   end

   qhpn_unmask u_unmask (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .operation    (req_tuser[0]),
      .short_header (req_tuser[1]),
      .first_byte   (req_tdata[7:0]),
      .pn_field     (req_tdata[39:8]),
      .mask         (req_tdata[79:40]),
      .pn_len_in    (req_tdata[82:80]),
      .max_rx_pn    (req_tdata[144:83]),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_data     (s1_data)
   );

   qhpn_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   qhpn_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .rx_phase  (rx_phase_ff),
      .lowest_pn (lowest_pn_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.key_set, rsp.packet_number, rsp.pn_len,
                       rsp.pn_field_out, rsp.first_byte_out};

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// QUIC header unprotect and packet number decode testbench
// Streams directed and random header requests through the block with random
// source gaps and sink stalls. Each accepted request is predicted from the
// header masking, packet number decode and key set selection rules, and every
// response is compared field by field in order. The key phase and lowest
// packet number registers are rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb;
   import qhpn_pkg::*;

   typedef struct {
      logic        operation;
      logic        short_header;
      logic [7:0]  first_byte;
      logic [31:0] pn_field;
      logic [39:0] mask;
      logic [2:0]  pn_len_in;
      logic [61:0] max_rx_pn;
   } hdr_req_type;

   localparam logic [63:0] PN_SPAN = {1'b0, PN_BOUND};
   localparam logic [63:0] PN_TOP  = PN_SPAN - 64'd1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic [PN_W-1:0]       csr_wdata = '0;

   logic        model_phase = 1'b0;
   logic [61:0] lowest_pn = '0;

   hdr_req_type pending_headers[$];
   rsp_type     awaited_headers[$];
   hdr_req_type held_header;
   int          send_wait = 0;
   int          recv_wait = 0;
   bit          send_idles = 1'b1;
   bit          recv_idles = 1'b1;
   int          mismatch_count = 0;

   quic_header_unprotect_pn_decode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] xor_pn_bytes(logic [31:0] field, logic [39:0] mask,
                                                int unsigned len);
      logic [31:0] res;
      res = field;
      for (int i = 0; i < 4; i++) begin
         if (i < len) begin
            res[31-8*i -: 8] = res[31-8*i -: 8] ^ mask[31-8*i -: 8];
         end
      end
      return res;
   endfunction

   function automatic logic [61:0] decode_pn(logic [61:0] largest, logic [31:0] trunc,
                                             int unsigned len);
      logic [63:0] next_pn;
      logic [63:0] win;
      logic [63:0] hwin;
      logic [63:0] cand;
      logic [63:0] res;
      next_pn = {2'b00, largest} + 64'd1;
      win     = 64'd1 << (8 * len);
      hwin    = win >> 1;
      cand    = (next_pn & ~(win - 64'd1)) | {32'd0, trunc};
      res     = cand;
      if (cand + hwin <= next_pn && cand < PN_SPAN - win) begin
         res = cand + win;
      end else if (cand > next_pn + hwin && cand >= win) begin
         res = cand - win;
      end
      if (res > PN_TOP) begin
         res = PN_TOP;
      end
      return res[61:0];
   endfunction

   function automatic rsp_type unmask_header(hdr_req_type h);
      rsp_type     r;
      logic [7:0]  bits;
      int unsigned len;
      r    = '0;
      bits = h.short_header ? BITS_SHORT : BITS_LONG;
      r.first_byte_out = h.first_byte ^ (h.mask[39:32] & bits);
      if (h.operation == OP_APPLY) begin
         r.pn_len       = h.pn_len_in;
         r.pn_field_out = xor_pn_bytes(h.pn_field, h.mask, 32'(h.pn_len_in));
      end else begin
         len            = 32'(r.first_byte_out[1:0]) + 32'd1;
         r.pn_len       = 3'(len);
         r.pn_field_out = xor_pn_bytes(h.pn_field, h.mask, len);
         r.packet_number = decode_pn(h.max_rx_pn, r.pn_field_out >> ((4 - len) * 8), len);
         if (h.short_header && r.first_byte_out[PHASE_BIT_POS] != model_phase) begin
            r.key_set = (r.packet_number < lowest_pn) ? KEY_PREVIOUS : KEY_NEXT;
         end
      end
      return r;
   endfunction

   function automatic hdr_req_type make_header(logic op, logic sh, logic [7:0] fb,
                                               logic [31:0] field, logic [39:0] mask,
                                               logic [2:0] len_in, logic [61:0] largest);
      hdr_req_type h;
      h.operation    = op;
      h.short_header = sh;
      h.first_byte   = fb;
      h.pn_field     = field;
      h.mask         = mask;
      h.pn_len_in    = len_in;
      h.max_rx_pn    = largest;
      return h;
   endfunction

   function automatic hdr_req_type random_header();
      hdr_req_type h;
      logic [63:0] r1;
      logic [63:0] r2;
      r1 = {$urandom, $urandom};
      r2 = {$urandom, $urandom};
      h.operation    = 1'($urandom_range(0, 1));
      h.short_header = 1'($urandom_range(0, 1));
      h.first_byte   = 8'($urandom);
      h.pn_field     = $urandom;
      h.mask         = r1[39:0];
      h.pn_len_in    = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
      case ($urandom_range(0, 4))
         0: h.max_rx_pn = 62'($urandom_range(0, 1000));
         1: h.max_rx_pn = PN_TOP[61:0] - 62'($urandom_range(0, 1000));
         2: h.max_rx_pn = r2[61:0];
         3: h.max_rx_pn = lowest_pn + 62'($urandom_range(0, 2000)) - 62'd1000;
         default: h.max_rx_pn = {r2[61:16], 16'hFFFF} - 62'($urandom_range(0, 2));
      endcase
      return h;
   endfunction

   function automatic int draw_pause(inout bit idles);
      if ($urandom_range(0, 39) == 0) begin
         idles = !idles;
      end
      return idles ? $urandom_range(0, 5) : 0;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_csr(logic idx, logic [61:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_KEY_PHASE) begin
         model_phase = value[0];
      end else begin
         lowest_pn = value;
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_headers.size() > 0 || req_tvalid || awaited_headers.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_headers.push_back(random_header());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = draw_pause(send_idles);
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_headers.push_back(unmask_header(held_header));
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait == 0 && pending_headers.size() > 0) begin
               held_header = pending_headers.pop_front();
               req_tdata  <= {7'd0, held_header.max_rx_pn, held_header.pn_len_in,
                              held_header.mask, held_header.pn_field,
                              held_header.first_byte};
               req_tuser  <= {held_header.short_header, held_header.operation};
               req_tvalid <= 1'b1;
               send_wait = draw_pause(send_idles);
            end else begin
               req_tvalid <= 1'b0;
               if (send_wait > 0) begin
                  send_wait--;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_headers.size() == 0) begin
               $error("response with no request outstanding: %0h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = awaited_headers.pop_front();
               check_field("first_byte_out", 64'(want.first_byte_out),
                           64'(rsp_tdata[7:0]));
               check_field("pn_field_out", 64'(want.pn_field_out),
                           64'(rsp_tdata[39:8]));
               check_field("pn_len", 64'(want.pn_len), 64'(rsp_tdata[42:40]));
               check_field("packet_number", 64'(want.packet_number),
                           64'(rsp_tdata[104:43]));
               check_field("key_set", 64'(want.key_set), 64'(rsp_tdata[106:105]));
            end
            recv_wait = draw_pause(recv_idles);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_KEY_PHASE, 62'd0);
      write_csr(CSR_LOWEST_PN, 62'd0);
      pending_headers.push_back(make_header(OP_APPLY, 1'b1, 8'h00, 32'h0, 40'h0, 3'd1, 62'd0));
      pending_headers.push_back(make_header(OP_APPLY, 1'b0, 8'hFF, 32'hFFFF_FFFF,
                                            40'hFF_FFFF_FFFF, 3'd4, PN_TOP[61:0]));
      pending_headers.push_back(make_header(OP_APPLY, 1'b1, 8'hA5, 32'h1234_5678,
                                            40'hFF_FFFF_FFFF, 3'd0, 62'd5));
      pending_headers.push_back(make_header(OP_APPLY, 1'b0, 8'h5A, 32'h8765_4321,
                                            40'hC3_A5A5_A5A5, 3'd7, 62'd5));
      pending_headers.push_back(make_header(OP_APPLY, 1'b1, 8'h3C, 32'hDEAD_BEEF,
                                            40'h5A_0F0F_0F0F, 3'd5, 62'd5));
      for (int n = 0; n < 4; n++) begin
         pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC0 | n[7:0],
                                               32'hA1B2_C3D4, 40'h0, 3'd1, 62'h1234_5678));
      end
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'h44, 32'h0100_0000, 40'h0,
                                            3'd1, 62'd300));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'h40, 32'h0100_0000, 40'h0,
                                            3'd1, 62'd300));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC0, 32'h0000_0000, 40'h0,
                                            3'd1, PN_TOP[61:0]));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC3, 32'hFFFF_FFFF, 40'h0,
                                            3'd1, PN_TOP[61:0]));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC0, 32'hFF00_0000, 40'h0,
                                            3'd1, 62'd0));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC0, 32'h0100_0000, 40'h0,
                                            3'd1, 62'h2FE));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b0, 8'hC0, 32'hF000_0000, 40'h0,
                                            3'd1, 62'h200));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'hFF, 32'hFFFF_FFFF,
                                            40'hFF_FFFF_FFFF, 3'd2, 62'h3_0000_0000));
      wait_drained();

      write_csr(CSR_KEY_PHASE, 62'd1);
      write_csr(CSR_LOWEST_PN, 62'd1000);
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'h40, 32'h0A00_0000, 40'h0,
                                            3'd1, 62'd10));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'h41, 32'h07E8_0000, 40'h0,
                                            3'd1, 62'd2000));
      pending_headers.push_back(make_header(OP_REMOVE, 1'b1, 8'h44, 32'h0A00_0000, 40'h0,
                                            3'd1, 62'd10));
      queue_random(250);
      wait_drained();

      write_csr(CSR_KEY_PHASE, 62'd0);
      write_csr(CSR_LOWEST_PN, PN_TOP[61:0]);
      queue_random(250);
      wait_drained();

      write_csr(CSR_KEY_PHASE, 62'd1);
      write_csr(CSR_LOWEST_PN, 62'd0);
      queue_random(250);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_KEY_PHASE, 62'($urandom_range(0, 1)));
         write_csr(CSR_LOWEST_PN, (p % 2 == 0) ? 62'({$urandom, $urandom})
                                              : 62'($urandom_range(0, 100000)));
         queue_random(250);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
